[src/grpm_pkg.sv]
// shared types and constants for the grid region priority maximum block
`default_nettype none

package grpm_pkg;

  // field widths
  localparam int COORD_W = 7;
  localparam int PRIO_W  = 9;

  // default grid size
  localparam int GRID_COLUMNS_DEF = 128;
  localparam int GRID_ROWS_DEF    = 128;

  // value of a cell that holds nothing yet
  localparam logic signed [PRIO_W-1:0] VACANT_PRIO = -9'sd1;

  // operation codes
  localparam logic OP_RAISE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } grpm_state_t;

endpackage : grpm_pkg

`default_nettype wire

[src/grid_region_priority_max_unit.sv]
// top level: priority map with rectangle raise and rectangle maximum query
//
// Command channel: an item is taken at a clock edge where start is high and
// busy is low. in_operation selects a raise (priorities in the rectangle are
// raised to in_priority_value where it is larger) or a query (largest
// priority in the rectangle). Parts of the rectangle outside the grid are
// skipped; an empty rectangle covers nothing.
// Result channel: a query gives exactly one result, shown on
// out_region_maximum for one cycle with out_valid high; a raise gives none.
// The receiver cannot stall, so results are never held back.
// Flow: the map sits in one ram with a registered read. Each covered
// cell goes through a read-modify-write stream; busy stays high while the
// covered cells are scanned and through a drain state after them, a query
// result shows in the first cycle with busy low again, and the next item
// can be taken at the end of that cycle. An item covering no cell
// leaves busy low; an empty query answers in the cycle after it is taken.
// Reset: the map of GRID_COLUMNS * GRID_ROWS cells (16384 by default) is
// swept to the vacant value one cell a cycle, with busy high throughout.
`default_nettype none

module grid_region_priority_max_unit
  import grpm_pkg::*;
#(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_operation,
  input  wire logic signed [PRIO_W-1:0] in_priority_value,
  input  wire logic [COORD_W-1:0]       in_x_first,
  input  wire logic [COORD_W-1:0]       in_x_last,
  input  wire logic [COORD_W-1:0]       in_y_first,
  input  wire logic [COORD_W-1:0]       in_y_last,
  output logic                          out_valid,
  output logic signed [PRIO_W-1:0]      out_region_maximum
);

  localparam int DEPTH = GRID_COLUMNS * GRID_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  grpm_state_t state_r, state_nxt;

  logic                     op_r, op_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic [COORD_W-1:0]       x_r, x_nxt;
  logic [COORD_W-1:0]       x1_r, x1_nxt;
  logic [COORD_W-1:0]       y_r, y_nxt;
  logic [COORD_W-1:0]       y0_r, y0_nxt;
  logic [COORD_W-1:0]       y1_r, y1_nxt;
  logic [AW-1:0]            col_base_r, col_base_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [AW-1:0]            wr_addr_r, wr_addr_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic signed [PRIO_W-1:0] best_r, best_nxt;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [PRIO_W-1:0] out_max_r, out_max_nxt;

  logic                     accept;
  logic                     covers;
  logic [COORD_W-1:0]       x1_clip;
  logic [COORD_W-1:0]       y1_clip;
  logic                     last_cell;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [PRIO_W-1:0]        ram_wdata;
  logic [PRIO_W-1:0]        ram_rdata;
  logic signed [PRIO_W-1:0] cur;

  // priority map storage
  grpm_ram #(
    .WIDTH(PRIO_W),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_map (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(addr_r),
    .rd_data(ram_rdata)
  );

  assign cur    = $signed(ram_rdata);
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  // rectangle clipping against the grid
  assign covers = (in_x_first <= in_x_last) && (in_y_first <= in_y_last) &&
                  (32'(in_x_first) < GRID_COLUMNS) && (32'(in_y_first) < GRID_ROWS);
  assign x1_clip = (32'(in_x_last) >= GRID_COLUMNS) ?
                   COORD_W'(GRID_COLUMNS - 1) : in_x_last;
  assign y1_clip = (32'(in_y_last) >= GRID_ROWS) ?
                   COORD_W'(GRID_ROWS - 1) : in_y_last;

  assign last_cell = (x_r == x1_r) && (y_r == y1_r);

  // write port: clearing sweep or conditional write back of the raise
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = VACANT_PRIO;
    end else begin
      ram_we    = rd_pend_r && (op_r == OP_RAISE) && (prio_r > cur);
      ram_waddr = wr_addr_r;
      ram_wdata = prio_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && covers) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_cell) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt        = op_r;
    prio_nxt      = prio_r;
    x_nxt         = x_r;
    x1_nxt        = x1_r;
    y_nxt         = y_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    col_base_nxt  = col_base_r;
    addr_nxt      = addr_r;
    wr_addr_nxt   = wr_addr_r;
    rd_pend_nxt   = 1'b0;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_max_nxt   = out_max_r;

    // running maximum over returned read data
    best_nxt = best_r;
    if (rd_pend_r && (op_r == OP_QUERY) && (cur > best_r)) begin
      best_nxt = cur;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = in_operation;
          prio_nxt     = in_priority_value;
          x_nxt        = in_x_first;
          x1_nxt       = x1_clip;
          y_nxt        = in_y_first;
          y0_nxt       = in_y_first;
          y1_nxt       = y1_clip;
          col_base_nxt = AW'(32'(in_x_first) * GRID_ROWS);
          addr_nxt     = AW'(32'(in_x_first) * GRID_ROWS + 32'(in_y_first));
          best_nxt     = VACANT_PRIO;
          // query with nothing covered answers without a scan
          if (!covers && (in_operation == OP_QUERY)) begin
            out_valid_nxt = 1'b1;
            out_max_nxt   = VACANT_PRIO;
          end
        end
      end
      ST_RUN: begin
        rd_pend_nxt = 1'b1;
        wr_addr_nxt = addr_r;
        if (y_r == y1_r) begin
          x_nxt        = x_r + COORD_W'(1);
          y_nxt        = y0_r;
          col_base_nxt = col_base_r + AW'(GRID_ROWS);
          addr_nxt     = col_base_r + AW'(GRID_ROWS) + AW'(y0_r);
        end else begin
          y_nxt    = y_r + COORD_W'(1);
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (op_r == OP_QUERY) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = best_nxt;
        end
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    prio_r     <= prio_nxt;
    x_r        <= x_nxt;
    x1_r       <= x1_nxt;
    y_r        <= y_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    col_base_r <= col_base_nxt;
    addr_r     <= addr_nxt;
    wr_addr_r  <= wr_addr_nxt;
    best_r     <= best_nxt;
    out_max_r  <= out_max_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_region_maximum = out_max_r;

  // a result follows only a finished query or an empty query
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r == ST_DRAIN && op_r == OP_QUERY) ||
                   $past(accept && !covers && in_operation == OP_QUERY)))
    else $error("result without a query behind it");

  // no read is outstanding once the block is idle again
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rd_pend_r)
    else $error("read still pending while idle");

  // write back only for a raise, and only ever upwards
  a_write_raise: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_CLEAR) |-> (op_r == OP_RAISE && $signed(ram_wdata) > cur))
    else $error("map written outside a raise or downwards");

  // a read is pending exactly in the cycle after each scan cycle
  a_pend_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == ST_RUN))
    else $error("pending read without a scan cycle");

endmodule : grid_region_priority_max_unit

`default_nettype wire

[src/grpm_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module grpm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : grpm_ram

`default_nettype wire

[tb/grpm_map_checker.sv]
// checker for the grid region priority maximum block: map predictor and result compare
`timescale 1ns / 100ps

module grpm_map_checker
  import grpm_pkg::*;
#(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_operation,
  input  logic signed [PRIO_W-1:0] in_priority_value,
  input  logic [COORD_W-1:0]       in_x_first,
  input  logic [COORD_W-1:0]       in_x_last,
  input  logic [COORD_W-1:0]       in_y_first,
  input  logic [COORD_W-1:0]       in_y_last,
  input  logic                     out_valid,
  input  logic signed [PRIO_W-1:0] out_region_maximum,
  output int                       fail_count,
  output int                       pending_count
);

  // predicted priority map and the queue of expected query answers
  logic signed [PRIO_W-1:0] prio_map [GRID_COLUMNS][GRID_ROWS];
  logic signed [PRIO_W-1:0] peak_queue [$];
  logic signed [PRIO_W-1:0] expected_peak;
  int                       mismatch_cnt = 0;

  // last covered index on one axis, clipped to the grid
  function automatic int clip_to_grid(input int last, input int size);
    return (last >= size) ? size - 1 : last;
  endfunction

  // largest priority in the rectangle, vacant value if it covers no cell
  function automatic logic signed [PRIO_W-1:0] region_peak(
    input int xf, input int xl, input int yf, input int yl
  );
    logic signed [PRIO_W-1:0] best;
    int                       x_end;
    int                       y_end;
    best  = VACANT_PRIO;
    x_end = clip_to_grid(xl, GRID_COLUMNS);
    y_end = clip_to_grid(yl, GRID_ROWS);
    for (int x = xf; x <= x_end; x++) begin
      for (int y = yf; y <= y_end; y++) begin
        if (prio_map[x][y] > best) best = prio_map[x][y];
      end
    end
    return best;
  endfunction

  // raise every cell of the rectangle to the new priority where it is larger
  task automatic raise_region(
    input logic signed [PRIO_W-1:0] prio,
    input int xf, input int xl, input int yf, input int yl
  );
    int x_end;
    int y_end;
    x_end = clip_to_grid(xl, GRID_COLUMNS);
    y_end = clip_to_grid(yl, GRID_ROWS);
    for (int x = xf; x <= x_end; x++) begin
      for (int y = yf; y <= y_end; y++) begin
        if (prio > prio_map[x][y]) prio_map[x][y] = prio;
      end
    end
  endtask

  // count a mismatch, print only the first few
  task automatic note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("checker: %s", what);
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (prio_map[i, j]) prio_map[i][j] = VACANT_PRIO;
      peak_queue.delete();
    end else begin
      // results first: an item taken at this edge cannot answer at the same edge
      if (out_valid) begin
        if (peak_queue.size() == 0) begin
          note_mismatch($sformatf("unexpected region maximum %0d with none pending",
                                  out_region_maximum));
        end else begin
          expected_peak = peak_queue.pop_front();
          if (out_region_maximum !== expected_peak)
            note_mismatch($sformatf("region maximum expected %0d, got %0d",
                                    expected_peak, out_region_maximum));
        end
      end
      // accepted item
      if (start && !busy) begin
        if (in_operation == OP_QUERY)
          peak_queue.push_back(region_peak(int'(in_x_first), int'(in_x_last),
                                           int'(in_y_first), int'(in_y_last)));
        else
          raise_region(in_priority_value, int'(in_x_first), int'(in_x_last),
                       int'(in_y_first), int'(in_y_last));
      end
    end
    fail_count    <= mismatch_cnt;
    pending_count <= peak_queue.size();
  end

endmodule : grpm_map_checker

[tb/tb_top.sv]
// testbench top for the grid region priority maximum block: stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
  import grpm_pkg::*;

  localparam int RANDOM_ITEMS = 1530;
  localparam int STALL_LIMIT  = 70000;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_operation;
  logic signed [PRIO_W-1:0] in_priority_value;
  logic [COORD_W-1:0]       in_x_first;
  logic [COORD_W-1:0]       in_x_last;
  logic [COORD_W-1:0]       in_y_first;
  logic [COORD_W-1:0]       in_y_last;
  logic                     out_valid;
  logic signed [PRIO_W-1:0] out_region_maximum;
  int                       fail_count;
  int                       pending_count;
  int                       stall_cycles = 0;
  bit                       gaps_on = 1'b1;

  grid_region_priority_max_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_priority_value (in_priority_value),
    .in_x_first        (in_x_first),
    .in_x_last         (in_x_last),
    .in_y_first        (in_y_first),
    .in_y_last         (in_y_last),
    .out_valid         (out_valid),
    .out_region_maximum(out_region_maximum)
  );

  grpm_map_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_priority_value (in_priority_value),
    .in_x_first        (in_x_first),
    .in_x_last         (in_x_last),
    .in_y_first        (in_y_first),
    .in_y_last         (in_y_last),
    .out_valid         (out_valid),
    .out_region_maximum(out_region_maximum),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles in which nothing is accepted and no result shows
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one item after an optional gap and hold it until taken
  task automatic issue_item(
    input logic                     op,
    input logic signed [PRIO_W-1:0] prio,
    input logic [COORD_W-1:0]       xf,
    input logic [COORD_W-1:0]       xl,
    input logic [COORD_W-1:0]       yf,
    input logic [COORD_W-1:0]       yl
  );
    int gap;
    bit taken;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      // idle with junk on the fields
      start             <= 1'b0;
      in_operation      <= 1'($urandom_range(0, 1));
      in_priority_value <= PRIO_W'($urandom_range(0, 511));
      in_x_first        <= COORD_W'($urandom_range(0, 127));
      in_x_last         <= COORD_W'($urandom_range(0, 127));
      in_y_first        <= COORD_W'($urandom_range(0, 127));
      in_y_last         <= COORD_W'($urandom_range(0, 127));
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_operation      <= op;
    in_priority_value <= prio;
    in_x_first        <= xf;
    in_x_last         <= xl;
    in_y_first        <= yf;
    in_y_last         <= yl;
    // busy is stable at the falling edge and decides the next rising edge
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  // random item: mostly small rectangles, some empty, a few very large
  task automatic random_item();
    logic                     op;
    logic signed [PRIO_W-1:0] prio;
    logic [COORD_W-1:0]       xf, xl, yf, yl;
    int                       pick;
    int                       kind;
    int                       span_hi;
    int                       reach;
    op   = $urandom_range(0, 1) ? OP_QUERY : OP_RAISE;
    pick = $urandom_range(0, 19);
    if (pick == 0)      prio = VACANT_PRIO;
    else if (pick == 1) prio = 9'sd255;
    else if (pick == 2) prio = PRIO_W'($urandom_range(0, 511));
    else                prio = PRIO_W'($urandom_range(0, 254));
    // half the items crowd one corner so raises and queries overlap
    span_hi = $urandom_range(0, 1) ? 31 : 127;
    kind    = $urandom_range(0, 99);
    if (kind < 8) begin
      // empty on one axis
      xf = COORD_W'($urandom_range(0, 127));
      xl = COORD_W'($urandom_range(0, 127));
      yf = COORD_W'($urandom_range(0, 127));
      yl = COORD_W'($urandom_range(0, 127));
      if ($urandom_range(0, 1)) begin
        xf = COORD_W'($urandom_range(1, 127));
        xl = COORD_W'($urandom_range(0, int'(xf) - 1));
      end else begin
        yf = COORD_W'($urandom_range(1, 127));
        yl = COORD_W'($urandom_range(0, int'(yf) - 1));
      end
    end else if (kind == 8) begin
      xf = COORD_W'($urandom_range(0, 15));
      xl = COORD_W'($urandom_range(64, 127));
      yf = COORD_W'($urandom_range(0, 15));
      yl = COORD_W'($urandom_range(64, 127));
    end else begin
      xf    = COORD_W'($urandom_range(0, span_hi));
      reach = int'(xf) + $urandom_range(0, 7);
      xl    = (reach > 127) ? 7'd127 : COORD_W'(reach);
      yf    = COORD_W'($urandom_range(0, span_hi));
      reach = int'(yf) + $urandom_range(0, 7);
      yl    = (reach > 127) ? 7'd127 : COORD_W'(reach);
    end
    issue_item(op, prio, xf, xl, yf, yl);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_operation      <= OP_RAISE;
    in_priority_value <= '0;
    in_x_first        <= '0;
    in_x_last         <= '0;
    in_y_first        <= '0;
    in_y_last         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whole grid after the clearing sweep, corners, extremes of priority
    issue_item(OP_QUERY, 9'sd7,       7'd0,   7'd127, 7'd0,   7'd127);
    issue_item(OP_RAISE, 9'sd254,     7'd0,   7'd0,   7'd0,   7'd0);
    issue_item(OP_RAISE, 9'sd255,     7'd127, 7'd127, 7'd127, 7'd127);
    issue_item(OP_RAISE, VACANT_PRIO, 7'd0,   7'd127, 7'd0,   7'd3);
    issue_item(OP_RAISE, 9'sh100,     7'd0,   7'd3,   7'd0,   7'd3);
    issue_item(OP_QUERY, 9'sh100,     7'd0,   7'd127, 7'd0,   7'd3);
    issue_item(OP_QUERY, 9'sd0,       7'd1,   7'd3,   7'd1,   7'd3);
    // empty rectangles on each axis
    issue_item(OP_RAISE, 9'sd200,     7'd5,   7'd4,   7'd0,   7'd10);
    issue_item(OP_RAISE, 9'sd100,     7'd0,   7'd10,  7'd9,   7'd8);
    issue_item(OP_QUERY, 9'sd0,       7'd127, 7'd0,   7'd0,   7'd127);
    issue_item(OP_QUERY, 9'sd0,       7'd0,   7'd127, 7'd127, 7'd0);
    issue_item(OP_QUERY, 9'sd0,       7'd0,   7'd10,  7'd0,   7'd10);
    issue_item(OP_QUERY, 9'sd0,       7'd127, 7'd127, 7'd127, 7'd127);
    // a full row and a full column, then a smaller raise over them
    issue_item(OP_RAISE, 9'sd10,      7'd0,   7'd127, 7'd64,  7'd64);
    issue_item(OP_RAISE, 9'sd3,       7'd64,  7'd64,  7'd0,   7'd127);
    issue_item(OP_QUERY, 9'sd0,       7'd64,  7'd64,  7'd0,   7'd127);
    issue_item(OP_RAISE, 9'sd0,       7'd5,   7'd9,   7'd5,   7'd9);
    issue_item(OP_QUERY, 9'sd0,       7'd5,   7'd9,   7'd5,   7'd9);
    issue_item(OP_RAISE, 9'sd200,     7'd63,  7'd65,  7'd63,  7'd65);
    issue_item(OP_QUERY, 9'sd0,       7'd60,  7'd64,  7'd0,   7'd63);
    issue_item(OP_QUERY, 9'sd0,       7'd0,   7'd127, 7'd0,   7'd127);

    // random part, with stretches free of gaps
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) gaps_on = ((n / 200) % 3) != 1;
      random_item();
    end
    start <= 1'b0;

    // drain, then let any trailing raise finish
    do @(negedge clk); while (pending_count != 0 || busy);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule : tb_top

[sim.f]
src/grpm_pkg.sv
src/grpm_ram.sv
src/grid_region_priority_max_unit.sv
tb/grpm_map_checker.sv
tb/tb_top.sv
